// ===== hw/rtl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the sampled derivative stream block.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // differences carry one extra bit so they never wrap
  localparam int DIFF_W     = DATA_WIDTH + 1;
  // scaled dividend: |dy| shifted up by the fraction bits
  localparam int DIVIDEND_W = DIFF_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

  localparam logic [DATA_WIDTH-1:0] SLOPE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SLOPE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] slope;
    logic                         zero_step;
    logic                         end_of_run;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic                         zero_step;
    logic signed [DATA_WIDTH-1:0] slope;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_LAUNCH,
    ST_DIV,
    ST_EMPTY
  } top_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_RUN,
    DV_CLAMP,
    DV_SIGN,
    DV_DONE
  } div_state_t;

endpackage

// ===== hw/rtl/sds_divider.sv =====
// ----------------------------------------------------------------------------
// sds_divider
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero, saturated to the signed output range. Zero divisor raises a flag.
// ----------------------------------------------------------------------------
module sds_divider (
  input  logic              clk,
  input  logic              rst,
  input  sds_pkg::div_req_t req,
  output sds_pkg::div_res_t res
);
  import sds_pkg::*;

  div_state_t              dv_state;
  div_state_t              dv_state_next;
  logic [DIVIDEND_W-1:0]   dq;       // dividend shifting out, quotient in
  logic [DIFF_W-1:0]       rem;
  logic [DIFF_W-1:0]       dmag;
  logic [CNT_W-1:0]        cnt;
  logic                    neg;
  logic                    zero_flag;
  logic [DATA_WIDTH-1:0]   slope;

  logic                    nneg;
  logic                    dneg;
  logic [DIFF_W-1:0]       nmag;
  logic [DIFF_W-1:0]       dmag_in;
  logic [DIFF_W:0]         rem_sh;
  logic [DIFF_W:0]         rem_sub;
  logic                    ge;
  logic [DIVIDEND_W-1:0]   limit;

  assign nneg    = req.num[DIFF_W-1];
  assign dneg    = req.den[DIFF_W-1];
  assign nmag    = nneg ? DIFF_W'(-req.num) : DIFF_W'(req.num);
  assign dmag_in = dneg ? DIFF_W'(-req.den) : DIFF_W'(req.den);

  assign rem_sh  = {rem, dq[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dmag};
  assign ge      = (rem_sh >= {1'b0, dmag});

  // most negative result has one more unit of magnitude
  assign limit   = neg ? DIVIDEND_W'(SLOPE_MIN) : DIVIDEND_W'(SLOPE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_state <= DV_IDLE;
    end else begin
      dv_state <= dv_state_next;
    end
  end

  always_comb begin
    dv_state_next = dv_state;
    unique case (dv_state)
      DV_IDLE, DV_DONE: begin
        if (req.start) begin
          dv_state_next = (dmag_in == '0) ? DV_DONE : DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt == CNT_W'(1)) begin
          dv_state_next = DV_CLAMP;
        end
      end
      DV_CLAMP: dv_state_next = DV_SIGN;
      DV_SIGN:  dv_state_next = DV_DONE;
      default:  dv_state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (dv_state)
      DV_IDLE, DV_DONE: begin
        if (req.start) begin
          dq        <= DIVIDEND_W'(nmag) << FRAC_BITS;
          rem       <= '0;
          dmag      <= dmag_in;
          cnt       <= CNT_W'(DIVIDEND_W);
          neg       <= nneg ^ dneg;
          zero_flag <= (dmag_in == '0);
          if (nmag == '0) begin
            slope <= '0;
          end else if (nneg) begin
            slope <= SLOPE_MIN;
          end else begin
            slope <= SLOPE_MAX;
          end
        end
      end
      DV_RUN: begin
        rem <= ge ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
        dq  <= {dq[DIVIDEND_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
      end
      DV_CLAMP: begin
        if (dq > limit) begin
          dq <= limit;
        end
      end
      DV_SIGN: begin
        slope <= neg ? DATA_WIDTH'(-dq[DATA_WIDTH-1:0]) : dq[DATA_WIDTH-1:0];
      end
      default: begin
      end
    endcase
  end

  assign res.done      = (dv_state == DV_DONE);
  assign res.zero_step = zero_flag;
  assign res.slope     = slope;

endmodule

// ===== hw/rtl/sampled_derivative_stream.sv =====
// ----------------------------------------------------------------------------
// sampled_derivative_stream
// Streaming slope estimator dy/dx over a run of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one (x, y) sample
//   per transfer, final_sample marking the last sample of a run. Output
//   channel (out_valid / out_stall / out_data) carries slopes, one sample
//   late: forward difference first, central differences inside the run,
//   backward difference on the final sample (end_of_run set).
//   The first sample of a run produces nothing. Every other sample produces
//   one slope, and the final one two. Each slope goes through the shared
//   restoring divider: setup (difference, then launch), one quotient
//   iteration per bit of the 49-bit scaled dividend, clamp and sign fix,
//   then the load into the output register. A zero x step skips the
//   iterations, the clamp and the sign fix; its slope is set at the launch.
//   A run of one sample returns slope 0 with end_of_run set.
//   in_stall is high while a sample is being worked on. The output register
//   decouples the sides: a new sample is taken while a slope waits, but a
//   finished quotient is held in the divider while the receiver stalls.
//   Synchronous reset clears the run state and drops out_valid.
// ----------------------------------------------------------------------------
module sampled_derivative_stream (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sds_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sds_pkg::out_item_t out_data
);
  import sds_pkg::*;

  top_state_t              state;
  top_state_t              state_next;

  // sample history
  logic [DATA_WIDTH-1:0]   x_prev;
  logic [DATA_WIDTH-1:0]   y_prev;
  logic [DATA_WIDTH-1:0]   x_prev2;
  logic [DATA_WIDTH-1:0]   y_prev2;
  logic [1:0]              seen;

  // sample under work
  logic [DATA_WIDTH-1:0]   x_cur;
  logic [DATA_WIDTH-1:0]   y_cur;
  logic                    last_cur;
  logic                    pass;     // set on the backward slope of a run

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;

  logic                    in_take;
  logic                    out_free;
  logic                    out_load;
  logic                    run_done; // history update at end of sample
  logic [DATA_WIDTH-1:0]   x_ref;
  logic [DATA_WIDTH-1:0]   y_ref;

  div_req_t                div_req;
  div_res_t                div_res;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // central slopes look two samples back, forward/backward slopes one
  assign x_ref = (!pass && seen == 2'd2) ? x_prev2 : x_prev;
  assign y_ref = (!pass && seen == 2'd2) ? y_prev2 : y_prev;

  assign div_req.start = (state == ST_LAUNCH);
  assign div_req.num   = dy;
  assign div_req.den   = dx;

  sds_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    run_done   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (seen == 2'd0) begin
            state_next = in_data.final_sample ? ST_EMPTY : ST_IDLE;
          end else begin
            state_next = ST_DIFF;
          end
        end
      end
      ST_DIFF:   state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV: begin
        if (div_res.done && out_free) begin
          out_load = 1'b1;
          if (!pass && last_cur) begin
            state_next = ST_DIFF;
          end else begin
            run_done   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 2'd0;
      pass <= 1'b0;
    end else begin
      if (in_take && seen == 2'd0 && !in_data.final_sample) begin
        seen <= 2'd1;
      end else if (run_done) begin
        seen <= last_cur ? 2'd0 : 2'd2;
      end
      if (state == ST_DIV && out_load) begin
        pass <= !pass && last_cur;
      end
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_cur    <= in_data.x_value;
      y_cur    <= in_data.y_value;
      last_cur <= in_data.final_sample;
      if (seen == 2'd0) begin
        x_prev <= in_data.x_value;
        y_prev <= in_data.y_value;
      end
    end else if (run_done) begin
      x_prev2 <= x_prev;
      y_prev2 <= y_prev;
      x_prev  <= x_cur;
      y_prev  <= y_cur;
    end
    if (state == ST_DIFF) begin
      dx <= {x_cur[DATA_WIDTH-1], x_cur} - {x_ref[DATA_WIDTH-1], x_ref};
      dy <= {y_cur[DATA_WIDTH-1], y_cur} - {y_ref[DATA_WIDTH-1], y_ref};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_EMPTY) begin
        out_data.slope      <= '0;
        out_data.zero_step  <= 1'b0;
        out_data.end_of_run <= 1'b1;
      end else begin
        out_data.slope      <= div_res.slope;
        out_data.zero_step  <= div_res.zero_step;
        out_data.end_of_run <= pass;
      end
    end
  end

  // checks
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen != 2'd3)
    else $error("seen count out of range");

  a_single_run: assert property (@(posedge clk) disable iff (rst)
    (in_take && seen == 2'd0 && in_data.final_sample) |=> (state == ST_EMPTY))
    else $error("single-sample run did not go to empty slope");

  a_first_sample: assert property (@(posedge clk) disable iff (rst)
    (in_take && seen == 2'd0 && !in_data.final_sample)
      |=> (state == ST_IDLE && seen == 2'd1))
    else $error("first sample of run not absorbed");

  a_backward_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && pass && out_load) |=> (out_valid && out_data.end_of_run))
    else $error("backward slope missing end_of_run");

endmodule

// ===== bench/tb_sampled_derivative_stream.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sampled_derivative_stream
// Self-checking bench for the streaming dy/dx slope estimator. A short table
// of hand-picked runs comes first, then random samples, to at least 950 rows in all, shaped
// into runs of varied length. A bit-true slope predictor works out every
// slope as each sample transfer is taken; the output side compares each slope
// transfer with the oldest pending prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_sampled_derivative_stream;

  import sds_pkg::*;

  localparam int CLK_HALF      = 6;     // 12 ns period
  localparam int RESET_CYCLES  = 12;
  localparam int SAMPLE_TARGET = 950;   // directed rows count towards this
  localparam int MAX_WAIT      = 19;    // longest idle drawn by either side
  localparam int PACE_SPAN     = 32;    // draws between changes of pace
  localparam int REPORT_LIMIT  = 10;
  // Covers the final sample's work in the divider, a full stall on both
  // slopes and a full sender gap, many times over.
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 150;

  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = SLOPE_MAX;
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = SLOPE_MIN;
  localparam logic signed [DATA_WIDTH-1:0] Q_ONE = 1 << FRAC_BITS;

  // How busy a side is over a stretch of draws
  typedef enum logic [1:0] {
    PACE_NONE,    // back to back, no idling at all
    PACE_SPARSE,  // mostly back to back, the odd gap
    PACE_BUSY     // gap drawn on every transfer
  } pace_t;

  // One row of stimulus. Pinned rows carry slopes read straight off the
  // spec; those are checked as written, the predictor only tracks state.
  typedef struct packed {
    in_item_t    item;
    logic        pinned;
    logic [1:0]  n_pinned;
    out_item_t   pin0;
    out_item_t   pin1;
  } sample_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sample_row_t sample_table[$];
  out_item_t   expected_slopes[$];
  int unsigned fail_count = 0;

  // Slope predictor state: the two most recent samples of the current run
  logic signed [DATA_WIDTH-1:0] newest_x, newest_y, older_x, older_y;
  int unsigned                  run_held = 0;

  sampled_derivative_stream i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Slope predictor
  // --------------------------------------------------------------------------

  // (ya - yb) * 2^FRAC_BITS / (xa - xb), truncated toward zero, saturated.
  // Differences are taken at 64 bits so they cannot wrap.
  function automatic out_item_t slope_between(
    input logic signed [DATA_WIDTH-1:0] ya, yb, xa, xb
  );
    longint            dy, dx;
    longint unsigned   dy_mag, dx_mag, quot, lim;
    bit                neg;
    out_item_t         r;
    r  = '0;
    dy = longint'(ya) - longint'(yb);
    dx = longint'(xa) - longint'(xb);
    if (dx == 0) begin
      // flat step in x: saturate by the sign of dy, zero if dy is zero too
      r.zero_step = 1'b1;
      if (dy > 0) r.slope = SLOPE_MAX;
      else if (dy < 0) r.slope = SLOPE_MIN;
      return r;
    end
    neg    = (dy < 0) != (dx < 0);
    dy_mag = (dy < 0) ? -dy : dy;
    dx_mag = (dx < 0) ? -dx : dx;
    quot   = (dy_mag << FRAC_BITS) / dx_mag;
    lim    = 64'd1 << (DATA_WIDTH - 1);
    if (!neg) lim = lim - 1;
    if (quot > lim) quot = lim;
    if (neg) quot = -quot;
    r.slope = quot[DATA_WIDTH-1:0];
    return r;
  endfunction

  // Steps the run state by one sample; returns how many slopes it releases
  function automatic int advance_run(input in_item_t s, output out_item_t first,
                                     output out_item_t second);
    int n;
    n      = 0;
    first  = '0;
    second = '0;
    if (run_held == 0) begin
      if (s.final_sample) begin
        // run of one sample: slope 0 and nothing stored
        first.end_of_run = 1'b1;
        return 1;
      end
      newest_x = s.x_value;
      newest_y = s.y_value;
      run_held = 1;
      return 0;
    end
    // forward difference for the second sample, central after that
    if (run_held == 1)
      first = slope_between(s.y_value, newest_y, s.x_value, newest_x);
    else
      first = slope_between(s.y_value, older_y, s.x_value, older_x);
    n = 1;
    if (s.final_sample) begin
      // backward difference for the final sample itself
      second = slope_between(s.y_value, newest_y, s.x_value, newest_x);
      second.end_of_run = 1'b1;
      n = 2;
      run_held = 0;
    end else begin
      run_held = 2;
    end
    older_x  = newest_x;
    older_y  = newest_y;
    newest_x = s.x_value;
    newest_y = s.y_value;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned draw_wait(input pace_t p);
    case (p)
      PACE_NONE:   return 0;
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
      default:     return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  function automatic out_item_t slope_word(input logic signed [DATA_WIDTH-1:0] s,
                                           input logic z, input logic e);
    out_item_t r;
    r.slope      = s;
    r.zero_step  = z;
    r.end_of_run = e;
    return r;
  endfunction

  function automatic sample_row_t plain(input logic signed [DATA_WIDTH-1:0] x, y,
                                        input logic fin);
    sample_row_t r;
    r = '0;
    r.item.x_value      = x;
    r.item.y_value      = y;
    r.item.final_sample = fin;
    return r;
  endfunction

  function automatic sample_row_t pinned(input logic signed [DATA_WIDTH-1:0] x, y,
                                         input logic fin, input int n,
                                         input out_item_t r0, input out_item_t r1);
    sample_row_t r;
    r          = plain(x, y, fin);
    r.pinned   = 1'b1;
    r.n_pinned = n[1:0];
    r.pin0     = r0;
    r.pin1     = r1;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus table: directed runs, then random runs
  // --------------------------------------------------------------------------
  initial begin : stimulus_table
    int unsigned                  run_len, x_style, y_style, pick;
    logic signed [DATA_WIDTH-1:0] x, y;

    // run of one sample straight after reset
    sample_table.push_back(pinned(0, 0, 1'b1, 1, slope_word(0, 1'b0, 1'b1), '0));
    // two-sample run, slope 2.0: forward and backward slopes agree
    sample_table.push_back(pinned(0, 0, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(Q_ONE, 2 * Q_ONE, 1'b1, 2,
                                  slope_word(2 * Q_ONE, 1'b0, 1'b0),
                                  slope_word(2 * Q_ONE, 1'b0, 1'b1)));
    // flat x step with rising y
    sample_table.push_back(pinned(5, 0, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(5, 100, 1'b1, 2, slope_word(Q_MAX, 1'b1, 1'b0),
                                  slope_word(Q_MAX, 1'b1, 1'b1)));
    // flat x step with falling y
    sample_table.push_back(pinned(-7, 0, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(-7, -1, 1'b1, 2, slope_word(Q_MIN, 1'b1, 1'b0),
                                  slope_word(Q_MIN, 1'b1, 1'b1)));
    // flat x step with flat y: zero slope, flag still set
    sample_table.push_back(pinned(3, 3, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(3, 3, 1'b1, 2, slope_word(0, 1'b1, 1'b0),
                                  slope_word(0, 1'b1, 1'b1)));
    // quotient overflow both ways: full-scale dy over the smallest dx
    sample_table.push_back(pinned(0, Q_MIN, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(1, Q_MAX, 1'b1, 2, slope_word(Q_MAX, 1'b0, 1'b0),
                                  slope_word(Q_MAX, 1'b0, 1'b1)));
    sample_table.push_back(pinned(0, Q_MAX, 1'b0, 0, '0, '0));
    sample_table.push_back(pinned(1, Q_MIN, 1'b1, 2, slope_word(Q_MIN, 1'b0, 1'b0),
                                  slope_word(Q_MIN, 1'b0, 1'b1)));
    // extremes of x and y; the third sample lands a flat central difference
    sample_table.push_back(plain(Q_MIN, Q_MAX, 1'b0));
    sample_table.push_back(plain(Q_MAX, Q_MIN, 1'b0));
    sample_table.push_back(plain(Q_MIN, 0, 1'b0));
    sample_table.push_back(plain(Q_MAX, 1, 1'b1));
    // ordinary run with central differences of both signs
    sample_table.push_back(plain(Q_ONE, 3 * Q_ONE, 1'b0));
    sample_table.push_back(plain(2 * Q_ONE, Q_ONE, 1'b0));
    sample_table.push_back(plain(4 * Q_ONE, -5 * Q_ONE, 1'b0));
    sample_table.push_back(plain(5 * Q_ONE + 123, 32'sh1234_5678, 1'b1));

    // Random runs: mostly well-formed sequences of a few samples, some runs
    // of one, a few long ones. x either wanders freely, sits on a handful of
    // values (many flat steps) or climbs in realistic steps.
    while (sample_table.size() < SAMPLE_TARGET) begin
      pick    = $urandom_range(0, 9);
      run_len = (pick == 0) ? 1 : (pick < 3) ? 2 :
                (pick < 9) ? $urandom_range(3, 12) : $urandom_range(13, 40);
      x_style = $urandom_range(0, 9);
      y_style = $urandom_range(0, 9);
      x       = $urandom;
      y       = $urandom;
      for (int k = 0; k < run_len; k++) begin
        if (x_style < 2)
          x = $urandom;
        else if (x_style < 4)
          x = $urandom_range(0, 3);
        else
          x = x + (($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32'h0003_0000));
        if (y_style < 3) begin
          y = $urandom;
        end else if (y_style < 5) begin
          case ($urandom_range(0, 4))
            0:       y = Q_MIN;
            1:       y = Q_MAX;
            2:       y = 0;
            3:       y = -1;
            default: y = $urandom;
          endcase
        end else begin
          y = y + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end
        sample_table.push_back(plain(x, y, k == run_len - 1));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample sender. Drives at the rising edge with nonblocking assignments; a
  // transfer is taken at an edge where in_valid is high and in_stall low. The
  // predictor runs at that edge, well before any slope can come back.
  // --------------------------------------------------------------------------
  initial begin : sample_sender
    sample_row_t row_now;
    out_item_t   p0, p1;
    int          n;
    int unsigned gap;
    int unsigned draws;
    pace_t       pace;

    draws    = 0;
    pace     = PACE_NONE;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (sample_table.size() != 0) begin
      row_now = sample_table.pop_front();
      if (draws % PACE_SPAN == 0) pace = pace_t'($urandom_range(0, 2));
      draws++;
      gap = draw_wait(pace);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // valid stays up across back-to-back transfers, payload just moves on
      in_valid <= 1'b1;
      in_data  <= row_now.item;
      do @(posedge clk); while (in_stall !== 1'b0);

      n = advance_run(row_now.item, p0, p1);
      if (row_now.pinned) begin
        n  = row_now.n_pinned;
        p0 = row_now.pin0;
        p1 = row_now.pin1;
      end
      if (n > 0) expected_slopes.push_back(p0);
      if (n > 1) expected_slopes.push_back(p1);
    end
    in_valid <= 1'b0;

    // Let the last slopes arrive, then watch a while for strays
    while (expected_slopes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Slope receiver and checker. Stalls at random before each slope, then
  // takes the next transfer and compares it field by field with the oldest
  // prediction.
  // --------------------------------------------------------------------------
  initial begin : slope_receiver
    out_item_t   want;
    out_item_t   got;
    int unsigned hold;
    int unsigned draws;
    pace_t       pace;

    draws     = 0;
    pace      = PACE_NONE;
    out_stall <= 1'b0;
    wait (rst == 1'b0);

    forever begin
      if (draws % PACE_SPAN == 0) pace = pace_t'($urandom_range(0, 2));
      draws++;
      hold = draw_wait(pace);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      if (expected_slopes.size() == 0) begin
        note_failure($sformatf("unexpected slope transfer: slope %h zero_step %b end_of_run %b",
                               got.slope, got.zero_step, got.end_of_run));
      end else begin
        want = expected_slopes.pop_front();
        if (got.slope !== want.slope || got.zero_step !== want.zero_step ||
            got.end_of_run !== want.end_of_run)
          note_failure($sformatf({"slope mismatch: expected slope %h zero_step %b ",
                                  "end_of_run %b, got slope %h zero_step %b end_of_run %b"},
                                 want.slope, want.zero_step, want.end_of_run,
                                 got.slope, got.zero_step, got.end_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if neither side sees a transfer for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sds_pkg.sv
hw/rtl/sds_divider.sv
hw/rtl/sampled_derivative_stream.sv
bench/tb_sampled_derivative_stream.sv
